FILE: design/touch_slider_position_core_macros.svh
// Assertion macros used by the controller module of the slider position core.
`ifndef TOUCH_SLIDER_POSITION_CORE_MACROS_SVH
`define TOUCH_SLIDER_POSITION_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TSP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slider position core: implication check failed");
`define TSP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slider position core: next-cycle check failed");
`else
`define TSP_ASSERT_IMP(label, clk, rst, ante, cons)
`define TSP_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: design/tsp_pkg.sv
`timescale 1ns / 1ps

package tsp_pkg;

   localparam int MAX_ELECTRODES = 16;
   localparam int COUNT_BITS     = 16;

   localparam int PTR_BITS   = $clog2(MAX_ELECTRODES);
   localparam int NUM_BITS   = PTR_BITS + 1;
   localparam int OP_BITS    = 2;
   localparam int CNT_FIELD  = 16;
   localparam int IDX_BITS   = 4;
   localparam int POS_BITS   = 8;
   localparam int ELEC_BITS  = 5;
   localparam int THR_BITS   = 16;
   localparam int QUOT_BITS  = 8;
   localparam int STEP_BITS  = $clog2(QUOT_BITS);
   localparam int PHASE_BITS = 1;
   localparam int SUM_BITS   = COUNT_BITS + 1;
   localparam int DIV_BITS   = COUNT_BITS + QUOT_BITS;
   localparam int ADDR_BITS  = 5;
   localparam int REG_BITS   = 3;
   localparam int DATA_BITS  = 32;

   localparam int SCALE_BITS      = 2 * POS_BITS;
   localparam int RECIP_BITS      = 13;
   localparam int RECIP_SHIFT     = 19;
   localparam int RECIP_PROD_BITS = SCALE_BITS + RECIP_BITS;

   localparam logic [POS_BITS-1:0] PERCENT_FULL = 8'd100;

   // Multiplying by this and shifting right by RECIP_SHIFT divides by 100 exactly for
   // every product of a percentage and a length.
   localparam logic [RECIP_BITS-1:0] RECIP_PERCENT = 13'd5243;

   localparam logic [OP_BITS-1:0] OP_CALIB = 2'd0;
   localparam logic [OP_BITS-1:0] OP_SCAN  = 2'd1;
   localparam logic [OP_BITS-1:0] OP_READ  = 2'd2;

   localparam logic [REG_BITS-1:0] REG_ELECTRODE_COUNT = 3'd0;
   localparam logic [REG_BITS-1:0] REG_THRESHOLD_FIRST = 3'd1;
   localparam logic [REG_BITS-1:0] REG_THRESHOLD_SECOND = 3'd2;
   localparam logic [REG_BITS-1:0] REG_STRIP_LENGTH    = 3'd3;
   localparam logic [REG_BITS-1:0] REG_NO_TOUCH_CODE   = 3'd4;

   localparam logic [PHASE_BITS-1:0] PH_P0 = 1'd0;
   localparam logic [PHASE_BITS-1:0] PH_P1 = 1'd1;

   localparam logic [ELEC_BITS-1:0] RST_ELECTRODE_COUNT = 5'd2;
   localparam logic [THR_BITS-1:0]  RST_THRESHOLD       = 16'd100;
   localparam logic [POS_BITS-1:0]  RST_STRIP_LENGTH    = 8'd40;
   localparam logic [POS_BITS-1:0]  RST_NO_TOUCH_CODE   = 8'd255;

   typedef struct packed {
      logic [ELEC_BITS-1:0] electrode_count;
      logic [THR_BITS-1:0]  threshold_first;
      logic [THR_BITS-1:0]  threshold_second;
      logic [POS_BITS-1:0]  strip_length;
      logic [POS_BITS-1:0]  no_touch_code;
   } cfg_type;

   typedef struct packed {
      logic [OP_BITS-1:0]   op;
      logic [CNT_FIELD-1:0] count;
   } req_type;

   typedef struct packed {
      logic [IDX_BITS-1:0] electrode_written;
      logic [IDX_BITS-1:0] next_electrode;
      logic [POS_BITS-1:0] position_percent;
      logic [POS_BITS-1:0] position_distance;
      logic                touched;
      logic                fresh;
   } rsp_type;

   typedef struct packed {
      logic                  load_item;
      logic                  div_load;
      logic                  div_step;
      logic                  div_save;
      logic                  scale_mul;
      logic                  scale_save;
      logic                  commit;
      logic [PHASE_BITS-1:0] phase;
   } cmd_type;

   typedef struct packed {
      logic fresh_read;
      logic touch;
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_LOAD,
      ST_STEP,
      ST_SAVE,
      ST_SCALE,
      ST_QUOT,
      ST_COMMIT
   } ctl_state_type;

endpackage

FILE: design/tsp_datapath.sv
`timescale 1ns / 1ps

module tsp_datapath (
   input  logic                clock,
   input  logic                reset,
   input  tsp_pkg::cfg_type    cfg,
   input  tsp_pkg::req_type    req_data,
   input  tsp_pkg::cmd_type    cmd,
   output tsp_pkg::status_type status,
   output tsp_pkg::rsp_type    rsp_data
);
   import tsp_pkg::*;

   req_type                    item_ff;
   rsp_type                    rsp_ff;
   rsp_type                    rsp_in;
   logic [COUNT_BITS-1:0]      baseline_ff [MAX_ELECTRODES];
   logic [COUNT_BITS-1:0]      delta_ff [MAX_ELECTRODES];
   logic [COUNT_BITS-1:0]      baseline_in;
   logic [COUNT_BITS-1:0]      delta_in;
   logic [PTR_BITS-1:0]        scan_ff;
   logic [PTR_BITS-1:0]        scan_in;
   logic [PTR_BITS-1:0]        calib_ff;
   logic [PTR_BITS-1:0]        calib_in;
   logic                       done_ff;
   logic                       done_in;
   logic [POS_BITS-1:0]        held_percent_ff;
   logic [POS_BITS-1:0]        held_percent_in;
   logic [POS_BITS-1:0]        held_distance_ff;
   logic [POS_BITS-1:0]        held_distance_in;
   logic                       held_touched_ff;
   logic                       held_touched_in;
   logic [DIV_BITS-1:0]        rem_ff;
   logic [DIV_BITS-1:0]        dvs_ff;
   logic [QUOT_BITS-1:0]       quot_ff;
   logic [QUOT_BITS-1:0]       p0_ff;
   logic [QUOT_BITS-1:0]       p1_ff;
   logic [QUOT_BITS-1:0]       q0_ff;
   logic [QUOT_BITS-1:0]       q1_ff;
   logic [SCALE_BITS-1:0]      scaled0_ff;
   logic [SCALE_BITS-1:0]      scaled1_ff;
   logic [RECIP_PROD_BITS-1:0] recip0;
   logic [RECIP_PROD_BITS-1:0] recip1;
   logic [NUM_BITS-1:0]        n_eff;
   logic [PTR_BITS-1:0]        calib_next;
   logic [PTR_BITS-1:0]        scan_next;
   logic [SUM_BITS-1:0]        delta_sum;
   logic [COUNT_BITS-1:0]      mul_a;
   logic [DIV_BITS-1:0]        product;
   logic                       rem_ge;
   logic                       touch;
   logic [POS_BITS:0]          percent_sum;
   logic [POS_BITS:0]          distance_sum;

   function automatic logic [PTR_BITS-1:0] advance(input logic [PTR_BITS-1:0] ptr,
                                                   input logic [NUM_BITS-1:0] n);
      if ((n - NUM_BITS'(1)) > {1'b0, ptr}) begin
         return ptr + PTR_BITS'(1);
      end
      return '0;
   endfunction

   always_comb begin
      if (cfg.electrode_count == '0) begin
         n_eff = NUM_BITS'(1);
      end else if (int'(cfg.electrode_count) > MAX_ELECTRODES) begin
         n_eff = NUM_BITS'(MAX_ELECTRODES);
      end else begin
         n_eff = NUM_BITS'(cfg.electrode_count);
      end
   end

   assign calib_next = advance(calib_ff, n_eff);
   assign scan_next  = advance(scan_ff, n_eff);

   assign touch = (THR_BITS'(delta_ff[0]) > cfg.threshold_first) ||
                  (THR_BITS'(delta_ff[1]) > cfg.threshold_second);

   assign status.fresh_read = (item_ff.op == OP_READ) && done_ff;
   assign status.touch      = touch;

   assign delta_sum = SUM_BITS'(delta_ff[0]) + SUM_BITS'(delta_ff[1]);

   always_comb begin
      case (cmd.phase)
         PH_P0:   mul_a = delta_ff[0];
         default: mul_a = delta_ff[1];
      endcase
   end

   assign product = DIV_BITS'(mul_a) * DIV_BITS'(PERCENT_FULL);
   assign rem_ge  = rem_ff >= dvs_ff;

   assign recip0 = RECIP_PROD_BITS'(scaled0_ff) * RECIP_PROD_BITS'(RECIP_PERCENT);
   assign recip1 = RECIP_PROD_BITS'(scaled1_ff) * RECIP_PROD_BITS'(RECIP_PERCENT);

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff  <= product;
         dvs_ff  <= DIV_BITS'({delta_sum, {(QUOT_BITS-1){1'b0}}});
         quot_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= rem_ge ? rem_ff - dvs_ff : rem_ff;
         dvs_ff  <= dvs_ff >> 1;
         quot_ff <= {quot_ff[QUOT_BITS-2:0], rem_ge};
      end
      if (cmd.div_save) begin
         case (cmd.phase)
            PH_P0:   p0_ff <= quot_ff;
            default: p1_ff <= quot_ff;
         endcase
      end
      if (cmd.scale_mul) begin
         scaled0_ff <= SCALE_BITS'(p0_ff) * SCALE_BITS'(cfg.strip_length);
         scaled1_ff <= SCALE_BITS'(p1_ff) * SCALE_BITS'(cfg.strip_length);
      end
      if (cmd.scale_save) begin
         q0_ff <= recip0[RECIP_SHIFT +: QUOT_BITS];
         q1_ff <= recip1[RECIP_SHIFT +: QUOT_BITS];
      end
      if (cmd.load_item) begin
         item_ff <= req_data;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign percent_sum  = (POS_BITS+1)'(PERCENT_FULL) - (POS_BITS+1)'(p0_ff)
                         + (POS_BITS+1)'(p1_ff);
   assign distance_sum = (POS_BITS+1)'(cfg.strip_length) - (POS_BITS+1)'(q0_ff)
                         + (POS_BITS+1)'(q1_ff);

   assign baseline_in = item_ff.count[COUNT_BITS-1:0];
   assign delta_in    = (baseline_in > baseline_ff[scan_ff])
                        ? baseline_in - baseline_ff[scan_ff] : '0;

   always_comb begin
      scan_in          = scan_ff;
      calib_in         = calib_ff;
      done_in          = done_ff;
      held_percent_in  = held_percent_ff;
      held_distance_in = held_distance_ff;
      held_touched_in  = held_touched_ff;
      rsp_in.electrode_written = '0;
      rsp_in.next_electrode    = IDX_BITS'(scan_ff);
      rsp_in.fresh             = 1'b0;
      case (item_ff.op)
         OP_CALIB: begin
            calib_in = calib_next;
            if (calib_next == '0) begin
               scan_in = '0;
            end
            rsp_in.electrode_written = IDX_BITS'(calib_ff);
            rsp_in.next_electrode    = IDX_BITS'(calib_next);
         end
         OP_SCAN: begin
            if (n_eff > NUM_BITS'(1)) begin
               scan_in = scan_next;
            end
            done_in = 1'b1;
            rsp_in.electrode_written = IDX_BITS'(scan_ff);
            rsp_in.next_electrode    = IDX_BITS'(scan_in);
         end
         OP_READ: begin
            if (done_ff) begin
               done_in      = 1'b0;
               rsp_in.fresh = 1'b1;
               if (touch) begin
                  held_percent_in  = percent_sum[POS_BITS:1];
                  held_distance_in = distance_sum[POS_BITS:1];
                  held_touched_in  = 1'b1;
               end else begin
                  held_percent_in  = cfg.no_touch_code;
                  held_distance_in = cfg.no_touch_code;
                  held_touched_in  = 1'b0;
               end
            end
         end
         default: begin
            done_in = done_ff;
         end
      endcase
      rsp_in.position_percent  = held_percent_in;
      rsp_in.position_distance = held_distance_in;
      rsp_in.touched           = held_touched_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff          <= '0;
         calib_ff         <= '0;
         done_ff          <= 1'b1;
         held_percent_ff  <= RST_NO_TOUCH_CODE;
         held_distance_ff <= RST_NO_TOUCH_CODE;
         held_touched_ff  <= 1'b0;
      end else if (cmd.commit) begin
         scan_ff          <= scan_in;
         calib_ff         <= calib_in;
         done_ff          <= done_in;
         held_percent_ff  <= held_percent_in;
         held_distance_ff <= held_distance_in;
         held_touched_ff  <= held_touched_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_ELECTRODES; i++) begin
            baseline_ff[i] <= '0;
            delta_ff[i]    <= '0;
         end
      end else if (cmd.commit) begin
         if (item_ff.op == OP_CALIB) begin
            baseline_ff[calib_ff] <= baseline_in;
         end
         if (item_ff.op == OP_SCAN) begin
            delta_ff[scan_ff] <= delta_in;
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

FILE: design/tsp_ctrl.sv
`timescale 1ns / 1ps
`include "touch_slider_position_core_macros.svh"

module tsp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  tsp_pkg::status_type status,
   output tsp_pkg::cmd_type    cmd
);
   import tsp_pkg::*;

   ctl_state_type         state_ff;
   ctl_state_type         state_in;
   logic [PHASE_BITS-1:0] phase_ff;
   logic [PHASE_BITS-1:0] phase_in;
   logic [STEP_BITS-1:0]  bit_ff;
   logic [STEP_BITS-1:0]  bit_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      bit_in         = bit_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      req_stall      = 1'b1;
      cmd.load_item  = 1'b0;
      cmd.div_load   = 1'b0;
      cmd.div_step   = 1'b0;
      cmd.div_save   = 1'b0;
      cmd.scale_mul  = 1'b0;
      cmd.scale_save = 1'b0;
      cmd.commit     = 1'b0;
      cmd.phase      = phase_ff;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.fresh_read && status.touch) begin
               phase_in = PH_P0;
               state_in = ST_LOAD;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            bit_in       = '0;
            state_in     = ST_STEP;
         end
         ST_STEP: begin
            cmd.div_step = 1'b1;
            if (bit_ff == STEP_BITS'(QUOT_BITS - 1)) begin
               state_in = ST_SAVE;
            end else begin
               bit_in = bit_ff + STEP_BITS'(1);
            end
         end
         ST_SAVE: begin
            cmd.div_save = 1'b1;
            if (phase_ff == PH_P1) begin
               state_in = ST_SCALE;
            end else begin
               phase_in = PH_P1;
               state_in = ST_LOAD;
            end
         end
         ST_SCALE: begin
            cmd.scale_mul = 1'b1;
            state_in      = ST_QUOT;
         end
         ST_QUOT: begin
            cmd.scale_save = 1'b1;
            state_in       = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   `TSP_ASSERT_NXT(a_accept_decides, clock, reset, req_valid && !req_stall,
                   state_ff == ST_DECIDE)
   `TSP_ASSERT_NXT(a_last_step_saves, clock, reset,
                   state_ff == ST_STEP && bit_ff == STEP_BITS'(QUOT_BITS - 1),
                   state_ff == ST_SAVE)
   `TSP_ASSERT_NXT(a_last_phase_scales, clock, reset,
                   state_ff == ST_SAVE && phase_ff == PH_P1, state_ff == ST_SCALE)
   `TSP_ASSERT_NXT(a_scale_then_quot, clock, reset, state_ff == ST_SCALE,
                   state_ff == ST_QUOT)
   `TSP_ASSERT_NXT(a_commit_shows_result, clock, reset, cmd.commit, rsp_valid_ff)

endmodule

FILE: design/touch_slider_position_core.sv
`timescale 1ns / 1ps
// Calibration samples, scan samples and reads without a new scan pass through ST_DECIDE
// and then ST_COMMIT after acceptance; a fresh read with a touch also runs the divider.
// The core takes one transaction at a time and commits it only when the output is free;
// a fresh touched read runs the 8-step serial divider twice, then a reciprocal scaling.
// Reset (synchronous, active high) clears both stores and pointers and sets the held
// positions to the no-touch code.

module touch_slider_position_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  tsp_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output tsp_pkg::rsp_type                      rsp_data,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [tsp_pkg::ADDR_BITS-1:0]         paddr,
   input  logic [tsp_pkg::DATA_BITS-1:0]         pwdata,
   output logic [tsp_pkg::DATA_BITS-1:0]         prdata,
   output logic                                  pready
);
   import tsp_pkg::*;

   cfg_type             cfg_ff;
   cfg_type             cfg_in;
   cmd_type             cmd;
   status_type          status;
   logic [REG_BITS-1:0] reg_index;
   logic                cfg_write;

   assign reg_index = paddr[ADDR_BITS-1:2];
   assign cfg_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_write) begin
         case (reg_index)
            REG_ELECTRODE_COUNT:  cfg_in.electrode_count  = pwdata[ELEC_BITS-1:0];
            REG_THRESHOLD_FIRST:  cfg_in.threshold_first  = pwdata[THR_BITS-1:0];
            REG_THRESHOLD_SECOND: cfg_in.threshold_second = pwdata[THR_BITS-1:0];
            REG_STRIP_LENGTH:     cfg_in.strip_length     = pwdata[POS_BITS-1:0];
            REG_NO_TOUCH_CODE:    cfg_in.no_touch_code    = pwdata[POS_BITS-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.electrode_count  <= RST_ELECTRODE_COUNT;
         cfg_ff.threshold_first  <= RST_THRESHOLD;
         cfg_ff.threshold_second <= RST_THRESHOLD;
         cfg_ff.strip_length     <= RST_STRIP_LENGTH;
         cfg_ff.no_touch_code    <= RST_NO_TOUCH_CODE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_index)
         REG_ELECTRODE_COUNT:  prdata = DATA_BITS'(cfg_ff.electrode_count);
         REG_THRESHOLD_FIRST:  prdata = DATA_BITS'(cfg_ff.threshold_first);
         REG_THRESHOLD_SECOND: prdata = DATA_BITS'(cfg_ff.threshold_second);
         REG_STRIP_LENGTH:     prdata = DATA_BITS'(cfg_ff.strip_length);
         REG_NO_TOUCH_CODE:    prdata = DATA_BITS'(cfg_ff.no_touch_code);
         default:              prdata = '0;
      endcase
   end

   tsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tsp_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import tsp_pkg::*;

   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
   localparam int unsigned CYCLE_LIMIT    = 500000;
   localparam int unsigned HOLDOFF_CYCLES = 600;
   localparam int unsigned DRAIN_CYCLES   = 50;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [ADDR_BITS-1:0] paddr = '0;
   logic [DATA_BITS-1:0] pwdata = '0;
   logic [DATA_BITS-1:0] prdata;
   logic                 pready;

   // Slider state as the block should hold it.
   logic [CNT_FIELD-1:0] base_cnt [MAX_ELECTRODES];
   logic [CNT_FIELD-1:0] delta_cnt [MAX_ELECTRODES];
   logic [IDX_BITS-1:0]  scan_idx;
   logic [IDX_BITS-1:0]  calib_idx;
   logic                 scan_pending;
   logic [POS_BITS-1:0]  held_pct;
   logic [POS_BITS-1:0]  held_dist;
   logic                 held_touch;

   logic [ELEC_BITS-1:0] ecount_cfg;
   logic [THR_BITS-1:0]  thr_first_cfg;
   logic [THR_BITS-1:0]  thr_second_cfg;
   logic [POS_BITS-1:0]  length_cfg;
   logic [POS_BITS-1:0]  no_touch_cfg;

   rsp_type     responses_due [$];
   rsp_type     due;
   int unsigned items_accepted = 0;
   int unsigned responses_checked = 0;
   int unsigned mismatches = 0;
   int unsigned touched_reads = 0;
   int unsigned settings_applied = 0;
   int unsigned cycle_count = 0;
   int unsigned hold_tickets = 0;
   int unsigned hold_served = 0;
   int unsigned hold_left = 0;
   logic        idle_on = 1'b0;

   touch_slider_position_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t ns: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("status: fail");
         $finish;
      end
   end

   task automatic reset_slider_model;
      foreach (base_cnt[i]) begin
         base_cnt[i] = '0;
         delta_cnt[i] = '0;
      end
      scan_idx = '0;
      calib_idx = '0;
      scan_pending = 1'b1;
      held_pct = RST_NO_TOUCH_CODE;
      held_dist = RST_NO_TOUCH_CODE;
      held_touch = 1'b0;
      ecount_cfg = RST_ELECTRODE_COUNT;
      thr_first_cfg = RST_THRESHOLD;
      thr_second_cfg = RST_THRESHOLD;
      length_cfg = RST_STRIP_LENGTH;
      no_touch_cfg = RST_NO_TOUCH_CODE;
   endtask

   function automatic int unsigned active_electrodes();
      if (ecount_cfg == 0) return 1;
      if (ecount_cfg > MAX_ELECTRODES) return MAX_ELECTRODES;
      return 32'(ecount_cfg);
   endfunction

   function automatic rsp_type compute_slider_response(req_type item);
      rsp_type     r;
      int unsigned n, d0, d1, s, p0, p1, q0, q1;
      r = '0;
      n = active_electrodes();
      case (item.op)
         OP_CALIB: begin
            base_cnt[calib_idx] = item.count;
            r.electrode_written = calib_idx;
            calib_idx = (n - 1 > calib_idx) ? IDX_BITS'(calib_idx + 1) : '0;
            if (calib_idx == 0) scan_idx = '0;
            r.next_electrode = calib_idx;
         end
         OP_SCAN: begin
            delta_cnt[scan_idx] = (item.count > base_cnt[scan_idx]) ?
                                  item.count - base_cnt[scan_idx] : '0;
            r.electrode_written = scan_idx;
            if (n > 1) scan_idx = (n - 1 > scan_idx) ? IDX_BITS'(scan_idx + 1) : '0;
            scan_pending = 1'b1;
            r.next_electrode = scan_idx;
         end
         OP_READ: begin
            if (scan_pending) begin
               scan_pending = 1'b0;
               r.fresh = 1'b1;
               d0 = 32'(delta_cnt[0]);
               d1 = 32'(delta_cnt[1]);
               if (d0 > thr_first_cfg || d1 > thr_second_cfg) begin
                  s = d0 + d1;
                  p0 = d0 * PERCENT_FULL / s;
                  p1 = d1 * PERCENT_FULL / s;
                  q0 = p0 * length_cfg / PERCENT_FULL;
                  q1 = p1 * length_cfg / PERCENT_FULL;
                  held_pct = POS_BITS'((PERCENT_FULL - p0 + p1) / 2);
                  held_dist = POS_BITS'((length_cfg - q0 + q1) / 2);
                  held_touch = 1'b1;
               end else begin
                  held_pct = no_touch_cfg;
                  held_dist = no_touch_cfg;
                  held_touch = 1'b0;
               end
            end
            r.next_electrode = scan_idx;
         end
         default: begin
            r.next_electrode = scan_idx;
         end
      endcase
      r.position_percent = held_pct;
      r.position_distance = held_dist;
      r.touched = held_touch;
      return r;
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (responses_due.size() == 0) begin
            $display("%0t ns: unexpected transaction, expected none, actual %p",
                     $time, rsp_data);
            mismatches++;
         end else begin
            due = responses_due.pop_front();
            check_field("electrode_written", due.electrode_written, rsp_data.electrode_written);
            check_field("next_electrode", due.next_electrode, rsp_data.next_electrode);
            check_field("position_percent", due.position_percent, rsp_data.position_percent);
            check_field("position_distance", due.position_distance, rsp_data.position_distance);
            check_field("touched", due.touched, rsp_data.touched);
            check_field("fresh", due.fresh, rsp_data.fresh);
            if (due.fresh && due.touched) touched_reads++;
         end
         responses_checked <= responses_checked + 1;
      end
   end

   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_served != hold_tickets) begin
         hold_served++;
         hold_left = HOLDOFF_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_on && ($urandom_range(99) < 6);
      end
   end

   task automatic send_item(input logic [OP_BITS-1:0] op, input logic [CNT_FIELD-1:0] count);
      req_type item;
      item.op = op;
      item.count = count;
      while (idle_on && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      responses_due.push_back(compute_slider_response(item));
      items_accepted++;
   endtask

   task automatic wait_for_responses;
      req_valid <= 1'b0;
      do @(posedge clock); while (responses_checked != items_accepted);
   endtask

   task automatic write_register(input logic [REG_BITS-1:0] index,
                                 input logic [DATA_BITS-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         REG_ELECTRODE_COUNT:  ecount_cfg = value[ELEC_BITS-1:0];
         REG_THRESHOLD_FIRST:  thr_first_cfg = value[THR_BITS-1:0];
         REG_THRESHOLD_SECOND: thr_second_cfg = value[THR_BITS-1:0];
         REG_STRIP_LENGTH:     length_cfg = value[POS_BITS-1:0];
         REG_NO_TOUCH_CODE:    no_touch_cfg = value[POS_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_settings(input int unsigned electrodes, input int unsigned thr_a,
                                 input int unsigned thr_b, input int unsigned len,
                                 input int unsigned code);
      wait_for_responses;
      write_register(REG_ELECTRODE_COUNT, electrodes);
      write_register(REG_THRESHOLD_FIRST, thr_a);
      write_register(REG_THRESHOLD_SECOND, thr_b);
      write_register(REG_STRIP_LENGTH, len);
      write_register(REG_NO_TOUCH_CODE, code);
      settings_applied++;
   endtask

   function automatic logic [CNT_FIELD-1:0] scan_count(logic [IDX_BITS-1:0] idx);
      int unsigned base, thr, c;
      base = 32'(base_cnt[idx]);
      thr = (idx == 1) ? 32'(thr_second_cfg) : 32'(thr_first_cfg);
      case ($urandom_range(7))
         0: c = $urandom_range(16'hFFFF);
         1: c = base - $urandom_range(base < 50 ? base : 50);
         2: c = base + thr + $urandom_range(2);
         default: c = base + $urandom_range(2 * thr + 64);
      endcase
      if (c > 16'hFFFF) c = 16'hFFFF;
      return CNT_FIELD'(c);
   endfunction

   task automatic run_traffic(input int unsigned target);
      int unsigned pick;
      int unsigned n;
      while (items_accepted < target) begin
         pick = $urandom_range(99);
         n = active_electrodes();
         if (pick < 8) begin
            send_item(OP_BITS'($urandom_range(3)), CNT_FIELD'($urandom()));
         end else if (pick < 18) begin
            repeat (n) send_item(OP_CALIB, ($urandom_range(3) != 0) ?
                                 CNT_FIELD'($urandom_range(3000)) :
                                 CNT_FIELD'($urandom_range(16'hFFFF)));
         end else if (pick < 24) begin
            repeat (2) send_item(OP_READ, CNT_FIELD'($urandom()));
         end else begin
            repeat (n) send_item(OP_SCAN, scan_count(scan_idx));
            send_item(OP_READ, CNT_FIELD'($urandom()));
         end
      end
   endtask

   task automatic test_reset_state;
      send_item(OP_READ, 16'h0000);
      send_item(OP_UNUSED, 16'hFFFF);
      send_item(OP_READ, 16'hFFFF);
      wait_for_responses;
   endtask

   task automatic test_directed_cases;
      send_item(OP_CALIB, 16'h0000);
      send_item(OP_CALIB, 16'hFFFF);
      send_item(OP_SCAN, 16'hFFFF);
      send_item(OP_SCAN, 16'h0000);
      send_item(OP_READ, 16'h0000);
      send_item(OP_READ, 16'h0000);
      send_item(OP_UNUSED, 16'hAAAA);
      send_item(OP_CALIB, 16'd100);
      send_item(OP_CALIB, 16'd100);
      send_item(OP_SCAN, 16'd150);
      send_item(OP_SCAN, 16'd400);
      send_item(OP_READ, 16'h5555);
      send_item(OP_SCAN, 16'd201);
      send_item(OP_SCAN, 16'd100);
      send_item(OP_READ, 16'h0000);
      send_item(OP_SCAN, 16'd200);
      send_item(OP_SCAN, 16'd200);
      send_item(OP_READ, 16'h0000);
      send_item(OP_SCAN, 16'd1100);
      send_item(OP_SCAN, 16'd1100);
      send_item(OP_READ, 16'h0000);
      send_item(OP_UNUSED, 16'h0000);
      wait_for_responses;
   endtask

   task automatic test_register_settings;
      idle_on <= 1'b1;
      apply_settings(1, 0, 0, 1, 0);
      run_traffic(items_accepted + 80);
      apply_settings(16, 16'hFFFF, 16'hFFFF, 255, 255);
      run_traffic(items_accepted + 80);
      apply_settings(0, 200, 50, 255, 17);
      run_traffic(items_accepted + 80);
      apply_settings(31, 300, 300, 100, 200);
      run_traffic(items_accepted + 80);
      apply_settings(2, $urandom_range(2000), $urandom_range(2000), $urandom_range(1, 255),
                     $urandom_range(255));
      run_traffic(items_accepted + 80);
      apply_settings(3, 20, 20, 1, 0);
      run_traffic(items_accepted + 80);
      apply_settings($urandom_range(1, 16), $urandom_range(500), $urandom_range(500),
                     $urandom_range(1, 255), $urandom_range(255));
      run_traffic(items_accepted + 80);
      apply_settings(2, 100, 100, 40, 255);
   endtask

   task automatic test_output_holdoff;
      hold_tickets <= hold_tickets + 1;
      run_traffic(items_accepted + 60);
      wait_for_responses;
   endtask

   task automatic test_random_traffic;
      idle_on <= 1'b0;
      run_traffic(items_accepted + 300);
      idle_on <= 1'b1;
      run_traffic(1600);
      apply_settings($urandom_range(4, 16), $urandom_range(300), $urandom_range(300),
                     $urandom_range(1, 255), $urandom_range(255));
      run_traffic(1650);
      wait_for_responses;
   endtask

   initial begin
      reset_slider_model;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_state;
      test_directed_cases;
      test_register_settings;
      test_output_holdoff;
      test_random_traffic;
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d transactions under %0d register settings, %0d fresh touched reads.",
               responses_checked, settings_applied, touched_reads);
      $display("Long output hold-off exercised %0d time(s); %0d mismatches seen.",
               hold_served, mismatches);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+design
design/tsp_pkg.sv
design/tsp_datapath.sv
design/tsp_ctrl.sv
design/touch_slider_position_core.sv
sim/tb_top.sv
